>>> hdl/bitmap_first_fit_allocator_macros.svh
// Assertion macros of the bitmap first-fit allocator, used by its controller.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BFFA_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("allocator check failed");
// Next-cycle implication, checked outside reset.
`define BFFA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("allocator check failed");
// Invariant, checked outside reset.
`define BFFA_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("allocator check failed");
`else
`define BFFA_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define BFFA_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`define BFFA_ASSERT_ALWAYS(label, clk, rst, expr)
`endif
`endif

>>> hdl/bffa_pkg.sv
// Types and constants of the bitmap first-fit allocator.
`timescale 1ns / 1ps
package bffa_pkg;

  localparam int CNT_W  = 13;
  localparam int BASE_W = 16;
  localparam int ADDR_W = 17;
  localparam int CFG_W  = 16;
  localparam int WIDE_W = 24;

  localparam logic [0:0] REG_ENTRY_COUNT  = 1'b0;
  localparam logic [0:0] REG_BASE_ADDRESS = 1'b1;

  localparam logic [CNT_W-1:0]  ENTRY_COUNT_RESET  = 13'd4096;
  localparam logic [BASE_W-1:0] BASE_ADDRESS_RESET = 16'd0;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] granted_address;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_CHK,
    ST_FREE_WR,
    ST_SUM_RD,
    ST_SUM_CHK,
    ST_MAP_CHK,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic sum_rd;
    logic sum_next;
    logic map_rd;
    logic alloc_commit;
    logic free_rd;
    logic free_commit;
    logic set_full;
    logic set_outside;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic in_range;
    logic sum_hit;
    logic sum_more;
  } stat_t;

endpackage

>>> hdl/bffa_dp.sv
// Datapath of the allocator: config registers, bitmap and summary memories, search logic.
`timescale 1ns / 1ps
module bffa_dp #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [bffa_pkg::CFG_W-1:0]    cfg_data,
  input  bffa_pkg::in_item_t            in_data,
  output bffa_pkg::out_item_t           out_data,
  input  bffa_pkg::cmd_t                cmd,
  output bffa_pkg::stat_t               stat
);

  localparam int MAP_WORDS = (MAX_ENTRIES + 31) / 32;
  localparam int SUM_WORDS = (MAP_WORDS + 31) / 32;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int WW        = SUM_AW + 5;
  localparam int KW        = WW + 5;
  localparam int WU_W      = bffa_pkg::CNT_W - 4;
  localparam int CW        = bffa_pkg::CNT_W;
  localparam int AW        = bffa_pkg::ADDR_W;
  localparam int XW        = bffa_pkg::WIDE_W;

  function automatic logic [5:0] first_zero(input logic [31:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) r = {1'b1, 5'(i)};
    end
    return r;
  endfunction

  // configuration
  logic [CW-1:0]              entry_count;
  logic [bffa_pkg::BASE_W-1:0] base_address;

  // memories
  logic [31:0] map_mem [MAP_WORDS];
  logic [31:0] sum_mem [SUM_WORDS];
  logic [31:0] map_rdata;
  logic [31:0] sum_rdata;

  // item registers
  bffa_pkg::op_t      op_q;
  logic [AW-1:0]      addr_q;
  logic [SUM_AW-1:0]  sum_ptr;
  logic [WW-1:0]      word_x;
  logic [MAP_AW-1:0]  clr_ptr;
  bffa_pkg::status_t  res_status;
  logic [AW-1:0]      res_granted;

  // combinational
  logic [CW-1:0]      count_eff;
  logic [WU_W-1:0]    words_used;
  logic [AW-1:0]      diff;
  logic               in_range;
  logic [31:0]        free_vec;
  logic [5:0]         sum_pe;
  logic               sum_more;
  logic [5:0]         map_pe;
  logic [KW-1:0]      alloc_k;
  logic               alloc_ok;
  logic [31:0]        alloc_word;
  logic [WW-1:0]      word_sel;
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [31:0]        map_wdata;
  logic               sum_we;
  logic [SUM_AW-1:0]  sum_waddr;
  logic [31:0]        sum_wdata;
  logic [SUM_AW-1:0]  sum_raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= bffa_pkg::ENTRY_COUNT_RESET;
      base_address <= bffa_pkg::BASE_ADDRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bffa_pkg::REG_ENTRY_COUNT:  entry_count  <= cfg_data[CW-1:0];
        bffa_pkg::REG_BASE_ADDRESS: base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_eff  = (XW'(entry_count) > XW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : entry_count;
    words_used = WU_W'((XW'(count_eff) + XW'(31)) >> 5);
    diff       = AW'(addr_q - AW'(base_address));
    in_range   = (addr_q >= AW'(base_address)) && (XW'(diff) < XW'(count_eff));

    // summary: zero bits whose map word still lies below the count
    for (int j = 0; j < 32; j++) begin
      free_vec[j] = !sum_rdata[j] && (XW'({sum_ptr, 5'(j)}) < XW'(words_used));
    end
    sum_pe   = first_zero(~free_vec);
    sum_more = (XW'(XW'(sum_ptr) + XW'(1)) << 5) < XW'(words_used);

    map_pe     = first_zero(map_rdata);
    alloc_k    = {word_x, map_pe[4:0]};
    alloc_ok   = map_pe[5] && (XW'(alloc_k) < XW'(count_eff));
    alloc_word = map_rdata | (32'd1 << map_pe[4:0]);

    word_sel = cmd.free_rd ? WW'(diff >> 5) : {sum_ptr, sum_pe[4:0]};
    sum_raddr = cmd.free_rd ? word_sel[WW-1:5] : sum_ptr;

    map_we    = 1'b0;
    map_waddr = word_x[MAP_AW-1:0];
    map_wdata = alloc_word;
    sum_we    = 1'b0;
    sum_waddr = word_x[WW-1:5];
    sum_wdata = sum_rdata | (32'd1 << word_x[4:0]);
    if (cmd.clr_step) begin
      map_we    = 1'b1;
      map_waddr = clr_ptr;
      map_wdata = '0;
      sum_we    = XW'(clr_ptr) < XW'(SUM_WORDS);
      sum_waddr = SUM_AW'(clr_ptr);
      sum_wdata = '0;
    end else if (cmd.alloc_commit) begin
      map_we = alloc_ok;
      sum_we = alloc_ok && (&alloc_word);
    end else if (cmd.free_commit) begin
      map_we    = 1'b1;
      map_wdata = map_rdata & ~(32'd1 << diff[4:0]);
      sum_we    = 1'b1;
      sum_wdata = sum_rdata & ~(32'd1 << word_x[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.map_rd || cmd.free_rd) map_rdata <= map_mem[word_sel[MAP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (cmd.sum_rd || cmd.free_rd) sum_rdata <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr <= clr_ptr + MAP_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= in_data.operation;
      addr_q  <= in_data.address;
      sum_ptr <= '0;
    end else if (cmd.sum_next) begin
      sum_ptr <= sum_ptr + SUM_AW'(1);
    end
    if (cmd.map_rd || cmd.free_rd) word_x <= word_sel;
    if (cmd.alloc_commit) begin
      res_status  <= alloc_ok ? bffa_pkg::STATUS_DONE : bffa_pkg::STATUS_FULL;
      res_granted <= alloc_ok ? AW'(XW'(base_address) + XW'(alloc_k)) : '0;
    end else if (cmd.free_commit) begin
      res_status  <= bffa_pkg::STATUS_DONE;
      res_granted <= '0;
    end else if (cmd.set_full) begin
      res_status  <= bffa_pkg::STATUS_FULL;
      res_granted <= '0;
    end else if (cmd.set_outside) begin
      res_status  <= bffa_pkg::STATUS_OUTSIDE;
      res_granted <= '0;
    end
    if (cmd.load_out) begin
      out_data.status          <= res_status;
      out_data.granted_address <= res_granted;
    end
  end

  assign stat.clr_last = (clr_ptr == MAP_AW'(MAP_WORDS - 1));
  assign stat.op_free  = (op_q == bffa_pkg::OP_FREE);
  assign stat.in_range = in_range;
  assign stat.sum_hit  = sum_pe[5];
  assign stat.sum_more = sum_more;

endmodule

>>> hdl/bffa_ctrl.sv
// Controller state machine of the allocator: sequences clear, search, update and output.
`timescale 1ns / 1ps
`include "bitmap_first_fit_allocator_macros.svh"
module bffa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bffa_pkg::cmd_t    cmd,
  input  bffa_pkg::stat_t   stat
);

  bffa_pkg::state_t state;
  bffa_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bffa_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      bffa_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = bffa_pkg::ST_IDLE;
      end
      bffa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = bffa_pkg::ST_SUM_RD;
          if (in_valid) state_next = bffa_pkg::ST_FREE_CHK;
        end
      end
      bffa_pkg::ST_FREE_CHK: begin
        if (!stat.op_free) begin
          state_next = bffa_pkg::ST_SUM_RD;
        end else if (stat.in_range) begin
          cmd.free_rd = 1'b1;
          state_next  = bffa_pkg::ST_FREE_WR;
        end else begin
          cmd.set_outside = 1'b1;
          state_next      = bffa_pkg::ST_PUSH;
        end
      end
      bffa_pkg::ST_FREE_WR: begin
        cmd.free_commit = 1'b1;
        state_next      = bffa_pkg::ST_PUSH;
      end
      bffa_pkg::ST_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_next = bffa_pkg::ST_SUM_CHK;
      end
      bffa_pkg::ST_SUM_CHK: begin
        if (stat.sum_hit) begin
          cmd.map_rd = 1'b1;
          state_next = bffa_pkg::ST_MAP_CHK;
        end else if (stat.sum_more) begin
          cmd.sum_next = 1'b1;
          state_next   = bffa_pkg::ST_SUM_RD;
        end else begin
          cmd.set_full = 1'b1;
          state_next   = bffa_pkg::ST_PUSH;
        end
      end
      bffa_pkg::ST_MAP_CHK: begin
        cmd.alloc_commit = 1'b1;
        state_next       = bffa_pkg::ST_PUSH;
      end
      bffa_pkg::ST_PUSH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  `BFFA_ASSERT_IMPLY(a_load_slot_free, clk, rst, cmd.load_out, (!out_valid || out_ready))
  `BFFA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, (in_valid && in_ready), !in_ready)
  `BFFA_ASSERT_IMPLY(a_clear_blocks_input, clk, rst, (state == bffa_pkg::ST_CLEAR), !in_ready)
  `BFFA_ASSERT_ALWAYS(a_one_writer, clk, rst,
    $onehot0({cmd.clr_step, cmd.alloc_commit, cmd.free_commit}))

endmodule

>>> hdl/bitmap_first_fit_allocator.sv
// Top level of the bitmap first-fit allocator: controller plus datapath.
`timescale 1ns / 1ps
// Bitmap first-fit allocator.
// Input channel (in_valid/in_ready, in_data): one item is an operation and
// an address. Allocate hands out the lowest free entry below entry_count and
// answers base_address plus its index, or status full. Free clears the entry
// at address minus base_address, or answers status outside if the address
// is not in the managed region. Output channel (out_valid/out_ready,
// out_data): exactly one result item per input item, in order.
// Configuration: cfg_we/cfg_index/cfg_data write entry_count (index 0) or
// base_address (index 1), one register per write; write them only while the block idles.
// Timing: one item at a time. A free checks the range, then writes the bitmap
// (no write when outside the region) and pushes its result. An allocate reads
// and checks the summary (one flag per 32-entry bitmap word) word by word until
// a flag shows a word with a free entry, then checks and updates that bitmap
// word, or answers full when the summary shows no free word.
// Reset: after rst a clearing pass writes the bitmap to all free, one word a
// cycle; in_ready stays low meanwhile.
// A stalled receiver holds the result in the output register; the block still
// accepts one more item and finishes it, then waits to hand its result over.
module bitmap_first_fit_allocator #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bffa_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bffa_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [bffa_pkg::CFG_W-1:0]  cfg_data
);

  // command and status between the sequencer and the datapath
  bffa_pkg::cmd_t  cmd;
  bffa_pkg::stat_t stat;

  // Sequencer: owns the handshakes and steps through clear, search and update.
  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: holds the registers, the bitmap and its summary of full words.
  bffa_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the bitmap first-fit allocator: directed and random requests.
`timescale 1ns / 1ps

// Shadow copy of the allocation bitmap and registers. Predicts one reply per
// accepted request and checks replies in order.
class grant_tracker;
  int unsigned                  capacity;
  bit                           taken[];
  logic [bffa_pkg::CNT_W-1:0]   entry_count;
  logic [bffa_pkg::BASE_W-1:0]  base_address;
  bffa_pkg::out_item_t          pending_replies[$];
  int                           failures;
  int                           allocs, frees, grants, fulls, outsides, top_index;

  function new(int unsigned cap);
    capacity = cap;
    taken = new[cap];
    entry_count = bffa_pkg::ENTRY_COUNT_RESET;
    base_address = bffa_pkg::BASE_ADDRESS_RESET;
    failures = 0;
    allocs = 0;
    frees = 0;
    grants = 0;
    fulls = 0;
    outsides = 0;
    top_index = -1;
  endfunction

  function void set_register(logic [0:0] index, logic [bffa_pkg::CFG_W-1:0] data);
    if (index == bffa_pkg::REG_ENTRY_COUNT)
      entry_count = data[bffa_pkg::CNT_W-1:0];
    else
      base_address = data[bffa_pkg::BASE_W-1:0];
  endfunction

  // Counts above the built capacity act as the capacity.
  function int unsigned managed();
    return (entry_count > capacity) ? capacity : entry_count;
  endfunction

  function void note_request(bffa_pkg::in_item_t item);
    bffa_pkg::out_item_t reply;
    int unsigned         lim, offset, k;
    bit                  hit;
    lim = managed();
    reply.status = bffa_pkg::STATUS_DONE;
    reply.granted_address = '0;
    hit = 1'b0;
    if (item.operation == bffa_pkg::OP_ALLOC) begin
      allocs++;
      for (k = 0; k < lim && !hit; k++) begin
        if (!taken[k]) begin
          taken[k] = 1'b1;
          reply.granted_address = bffa_pkg::ADDR_W'(base_address + k);
          hit = 1'b1;
          grants++;
          if (int'(k) > top_index)
            top_index = k;
        end
      end
      if (!hit) begin
        reply.status = bffa_pkg::STATUS_FULL;
        fulls++;
      end
    end else begin
      frees++;
      offset = item.address - base_address;
      if (item.address < base_address || offset >= lim) begin
        reply.status = bffa_pkg::STATUS_OUTSIDE;
        outsides++;
      end else begin
        taken[offset] = 1'b0;
      end
    end
    pending_replies.push_back(reply);
  endfunction

  function void check_reply(bffa_pkg::out_item_t got);
    bffa_pkg::out_item_t want;
    if (pending_replies.size() == 0) begin
      failures++;
      $display("%0t: reply with no request pending: expected none, actual status %0d address %0d",
               $time, got.status, got.granted_address);
      return;
    end
    want = pending_replies.pop_front();
    if (got.status !== want.status) begin
      failures++;
      $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, got.status);
    end
    if (got.granted_address !== want.granted_address) begin
      failures++;
      $display("%0t: granted_address mismatch: expected %0d, actual %0d",
               $time, want.granted_address, got.granted_address);
    end
  endfunction
endclass

module testbench;
  localparam int MAX_ENTRIES = 4096;
  // Cycles without any item moving before the run is declared hung; covers
  // the clearing pass after reset and long random receiver stalls.
  localparam int STALL_LIMIT = 4000;

  typedef enum int {
    PACE_SLOW_SINK,    // sender idles 29%, receiver stalls 59%
    PACE_SLOW_SOURCE,  // sender idles 59%, receiver stalls 29%
    PACE_STEADY        // no idling on either side
  } pace_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  bffa_pkg::in_item_t          in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  bffa_pkg::out_item_t         out_data;
  logic                        cfg_we = 1'b0;
  logic [0:0]                  cfg_index = bffa_pkg::REG_ENTRY_COUNT;
  logic [bffa_pkg::CFG_W-1:0]  cfg_data = '0;

  pace_t        pace = PACE_SLOW_SINK;
  int           quiet_cycles = 0;
  grant_tracker board = new(MAX_ENTRIES);

  bitmap_first_fit_allocator #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: pick out_ready for the coming edge, then check whatever moved
  // at that edge. Values read right after the edge are the pre-edge ones.
  initial begin
    forever begin
      out_ready <= ($urandom_range(0, 99) >=
                    ((pace == PACE_SLOW_SINK) ? 59 : (pace == PACE_SLOW_SOURCE) ? 29 : 0));
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        board.check_reply(out_data);
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d replies outstanding",
                 $time, STALL_LIMIT, board.pending_replies.size());
        $display("[bitmap_first_fit_allocator] ERROR");
        $finish;
      end
    end
  end

  // Offer one request, optionally after random idle cycles, and hold it
  // until accepted. Valid is left high; the caller decides what comes next.
  task automatic send_request(bffa_pkg::in_item_t item);
    while ($urandom_range(0, 99) <
           ((pace == PACE_SLOW_SINK) ? 29 : (pace == PACE_SLOW_SOURCE) ? 59 : 0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    board.note_request(item);
  endtask

  task automatic request(bffa_pkg::op_t op, logic [bffa_pkg::ADDR_W-1:0] address);
    bffa_pkg::in_item_t item;
    item.operation = op;
    item.address = address;
    send_request(item);
  endtask

  // Drop valid and wait until every reply is back so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges. Junk in the unused upper bits
  // of the count word must be dropped by the block.
  task automatic configure(int unsigned count, int unsigned base);
    logic [bffa_pkg::CFG_W-1:0] count_word;
    count_word = bffa_pkg::CFG_W'(count) |
                 (bffa_pkg::CFG_W'($urandom_range(0, 7)) << bffa_pkg::CNT_W);
    cfg_we <= 1'b1;
    cfg_index <= bffa_pkg::REG_ENTRY_COUNT;
    cfg_data <= count_word;
    @(posedge clk);
    board.set_register(bffa_pkg::REG_ENTRY_COUNT, count_word);
    cfg_index <= bffa_pkg::REG_BASE_ADDRESS;
    cfg_data <= bffa_pkg::CFG_W'(base);
    @(posedge clk);
    board.set_register(bffa_pkg::REG_BASE_ADDRESS, bffa_pkg::CFG_W'(base));
    cfg_we <= 1'b0;
  endtask

  // Random request. Frees mostly hit the managed region (often used entries,
  // sometimes already free ones); the rest probe the edges, the extremes and random addresses.
  function automatic bffa_pkg::in_item_t make_request(int alloc_pct);
    bffa_pkg::in_item_t item;
    int unsigned        lim, base;
    lim = board.managed();
    base = board.base_address;
    item.address = bffa_pkg::ADDR_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      item.operation = bffa_pkg::OP_ALLOC;
    end else begin
      item.operation = bffa_pkg::OP_FREE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: if (lim != 0)
          item.address = bffa_pkg::ADDR_W'(base + $urandom_range(0, lim - 1));
        6: item.address = $urandom_range(0, 1) ? '1 : '0;
        7: item.address = bffa_pkg::ADDR_W'(base - 1);  // with base 0 this wraps to the top
        8: item.address = bffa_pkg::ADDR_W'(base + lim);
        default: ;
      endcase
    end
    return item;
  endfunction

  // One register setting; pacing walks through the three modes in thirds.
  task automatic run_phase(int unsigned count, int unsigned base, int n, int alloc_pct);
    settle();
    configure(count, base);
    for (int i = 0; i < n; i++) begin
      pace = pace_t'(i * 3 / n);
      send_request(make_request(alloc_pct));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: lowest-first grants, double free, region edges.
    pace = PACE_SLOW_SINK;
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_ALLOC, 17'd131071);
    request(bffa_pkg::OP_FREE, 17'd0);
    request(bffa_pkg::OP_FREE, 17'd0);
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_FREE, 17'd131071);
    request(bffa_pkg::OP_FREE, 17'd4095);
    request(bffa_pkg::OP_FREE, 17'd4096);
    request(bffa_pkg::OP_FREE, 17'd0);
    request(bffa_pkg::OP_FREE, 17'd1);

    // Two entries at the top base: grant past 16 bits, full, below-base free.
    settle();
    configure(2, 65535);
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_FREE, 17'd65534);
    request(bffa_pkg::OP_FREE, 17'd65537);
    request(bffa_pkg::OP_FREE, 17'd65536);
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_FREE, 17'd65535);
    request(bffa_pkg::OP_FREE, 17'd65536);

    // Zero entries: everything is full or outside.
    settle();
    configure(0, 100);
    request(bffa_pkg::OP_ALLOC, 17'd0);
    request(bffa_pkg::OP_FREE, 17'd100);

    // Count above capacity clamps to the capacity.
    settle();
    configure(8191, 0);
    request(bffa_pkg::OP_FREE, 17'd4095);
    request(bffa_pkg::OP_FREE, 17'd4096);
    request(bffa_pkg::OP_ALLOC, 17'd0);

    // Fill past the first summary word so the search has to skip full words.
    run_phase(8191, $urandom_range(0, 65535), 1150, 97);
    run_phase(1, 65535, 60, 50);
    run_phase(0, $urandom_range(0, 65535), 40, 50);
    run_phase(37, $urandom_range(0, 65535), 100, 55);
    run_phase(300, $urandom_range(0, 65535), 100, 50);

    settle();
    repeat (16) @(posedge clk);

    $display("Covered %0d requests (%0d allocate, %0d free) across nine register settings.",
             board.allocs + board.frees, board.allocs, board.frees);
    $display("Saw %0d grants up to index %0d, %0d full answers, %0d out-of-region frees.",
             board.grants, board.top_index, board.fulls, board.outsides);
    if (board.failures == 0)
      $display("[bitmap_first_fit_allocator] OK");
    else
      $display("[bitmap_first_fit_allocator] ERROR");
    $finish;
  end
endmodule
